@@ hw/rtl/ampq_pkg.sv @@
// Shared types and constants of the array priority queue.
`default_nettype none

package ampq_pkg;

    localparam int DATA_W    = 32;
    localparam int PRIO_IN_W = 16;
    localparam int OCC_W     = 8;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        KIND_INSERT  = 1'b0,
        KIND_EXTRACT = 1'b1
    } kind_t;

endpackage

`default_nettype wire

@@ hw/rtl/array_max_priority_queue.sv @@
// Array priority queue: insert at the tail, extract the max by scanning the entry RAM.
// Insert: result registered at acceptance; 1 word per cycle when the output drains.
// Extract: the result follows the one-read-per-cycle scan of the entry RAM and the
// write-back of the last entry into the slot of the extracted max.
// Extract from an empty and insert into a full queue return a status with no scan.
// rst_n (async, active low) empties the queue; RAM contents are not cleared.
`default_nettype none

module array_max_priority_queue #(
    parameter int CAPACITY      = 128,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // data_in[31:0], priority_in[47:32]
    input  wire logic        s_axis_tuser,   // kind[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // data_out[31:0], priority_out[47:32],
                                             // occupancy[55:48]
    output logic [3:0]       m_axis_tuser    // status[1:0], is_empty[2], is_full[3]
);

    localparam int PrioW = (PRIORITY_BITS < ampq_pkg::PRIO_IN_W) ? PRIORITY_BITS
                                                                 : ampq_pkg::PRIO_IN_W;
    localparam int EntW  = ampq_pkg::DATA_W + PrioW;
    localparam int AddrW = $clog2(CAPACITY);
    localparam int CntW  = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    // entry RAM
    logic [EntW-1:0]  mem [CAPACITY];
    logic             mem_we;
    logic [AddrW-1:0] mem_waddr;
    logic [EntW-1:0]  mem_wdata;
    logic [EntW-1:0]  rd_data_reg;

    state_t                           state_reg, state_next;
    logic [CntW-1:0]                  count_reg, count_next;
    logic [AddrW-1:0]                 rd_idx_reg, rd_idx_next;
    logic                             issue_reg, issue_next;
    logic                             cmp_vld_reg, cmp_vld_next;
    logic [AddrW-1:0]                 cmp_idx_reg, cmp_idx_next;
    logic [AddrW-1:0]                 last_idx_reg, last_idx_next;
    logic [AddrW-1:0]                 best_idx_reg, best_idx_next;
    logic [PrioW-1:0]                 best_prio_reg, best_prio_next;
    logic [ampq_pkg::DATA_W-1:0]      best_data_reg, best_data_next;
    logic [EntW-1:0]                  last_ent_reg, last_ent_next;

    logic                             out_valid_reg, out_valid_next;
    logic [ampq_pkg::DATA_W-1:0]      out_data_reg, out_data_next;
    logic [PrioW-1:0]                 out_prio_reg, out_prio_next;
    ampq_pkg::status_t                out_status_reg, out_status_next;
    logic [CntW-1:0]                  out_count_reg, out_count_next;

    logic                             out_free;
    logic                             accept;
    logic                             full;
    logic [CntW-1:0]                  count_dec;
    logic [PrioW-1:0]                 rd_prio;
    logic [ampq_pkg::DATA_W-1:0]      rd_data;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == CntW'(CAPACITY));
    assign count_dec     = count_reg - CntW'(1);
    assign rd_prio       = rd_data_reg[PrioW-1:0];
    assign rd_data       = rd_data_reg[EntW-1:PrioW];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        issue_next      = issue_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        last_idx_next   = last_idx_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_data_next  = best_data_reg;
        last_ent_next   = last_ent_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_prio_next   = out_prio_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AddrW-1:0];
        mem_wdata       = {s_axis_tdata[ampq_pkg::DATA_W-1:0],
                           s_axis_tdata[ampq_pkg::DATA_W +: PrioW]};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_data_next = '0;
                    out_prio_next = '0;
                    if (s_axis_tuser == ampq_pkg::KIND_INSERT)
                    begin
                        out_valid_next = 1'b1;
                        if (full)
                        begin
                            out_status_next = ampq_pkg::STATUS_FULL;
                            out_count_next  = count_reg;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            count_next      = count_reg + CntW'(1);
                            out_status_next = ampq_pkg::STATUS_OK;
                            out_count_next  = count_reg + CntW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ampq_pkg::STATUS_EMPTY;
                        out_count_next  = count_reg;
                    end
                    else
                    begin
                        rd_idx_next   = '0;
                        issue_next    = 1'b1;
                        last_idx_next = count_dec[AddrW-1:0];
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // read issue: one address per cycle, data compared in the next cycle
                if (issue_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg;
                    if (rd_idx_reg == last_idx_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + AddrW'(1);
                    end
                end
                if (cmp_vld_reg)
                begin
                    // strict compare keeps the lowest slot among equal maxima
                    if (cmp_idx_reg == '0 || rd_prio > best_prio_reg)
                    begin
                        best_idx_next  = cmp_idx_reg;
                        best_prio_next = rd_prio;
                        best_data_next = rd_data;
                    end
                    if (cmp_idx_reg == last_idx_reg)
                    begin
                        last_ent_next = rd_data_reg;
                        state_next    = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    // last entry fills the hole; harmless when best is the last slot
                    mem_we          = 1'b1;
                    mem_waddr       = best_idx_reg;
                    mem_wdata       = last_ent_reg;
                    count_next      = count_dec;
                    out_valid_next  = 1'b1;
                    out_data_next   = best_data_reg;
                    out_prio_next   = best_prio_reg;
                    out_status_next = ampq_pkg::STATUS_OK;
                    out_count_next  = count_dec;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        last_idx_reg   <= last_idx_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_data_reg  <= best_data_next;
        last_ent_reg   <= last_ent_next;
        out_data_reg   <= out_data_next;
        out_prio_reg   <= out_prio_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {ampq_pkg::OCC_W'(out_count_reg),
                            ampq_pkg::PRIO_IN_W'(out_prio_reg),
                            out_data_reg};
    assign m_axis_tuser  = {(out_count_reg == CntW'(CAPACITY)),
                            (out_count_reg == '0),
                            out_status_reg};

endmodule

`default_nettype wire
